// ----- design/linear_probe_hash_table_top_defines.svh -----
// assertion macros for the linear probe hash table
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LPHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/lpht_pkg.sv -----
// types, constants and hash function for the linear probe hash table
`default_nettype none
package lpht_pkg;

    localparam int SLOTS       = 31;
    localparam int SLOT_W      = 5;
    localparam int KEY_W       = 31;
    localparam int PAY_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    // home slot folds 5-bit digits, valid because SLOTS is 2**SLOT_W - 1
    localparam int DIGITS     = (KEY_W + SLOT_W - 1) / SLOT_W;
    localparam int HASH_EXT_W = DIGITS * SLOT_W;
    localparam int SUM_W      = SLOT_W + $clog2(DIGITS + 1);

    // result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd4;

    // operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PAY_W-1:0]    found_payload;
    } t_out;

    // classified job passed from front to back
    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [SLOT_W-1:0] home;
        logic              bad;
    } t_job;

    // key mod SLOTS: sum of base-32 digits, then one fold and one subtract
    function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [HASH_EXT_W-1:0] ext;
        logic [SUM_W-1:0]      sum;
        logic [SLOT_W:0]       fold;
        ext = HASH_EXT_W'(key);
        sum = '0;
        for (int d = 0; d < DIGITS; d++) begin
            sum = sum + SUM_W'(ext[d*SLOT_W +: SLOT_W]);
        end
        fold = (SLOT_W+1)'(sum[SUM_W-1:SLOT_W]) + (SLOT_W+1)'(sum[SLOT_W-1:0]);
        if (fold >= (SLOT_W+1)'(SLOTS)) begin
            fold = fold - (SLOT_W+1)'(SLOTS);
        end
        return fold[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/lpht_front.sv -----
// front stage: accepts items, rejects key zero, computes the home slot
`default_nettype none
module lpht_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  lpht_pkg::t_in    i_item,
    output logic             o_valid,
    input  wire              i_stall,
    output lpht_pkg::t_job   o_job
);
    import lpht_pkg::*;

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    // classify the incoming item
    always_comb begin
        n_job.kind    = i_item.kind;
        n_job.key     = i_item.key;
        n_job.payload = i_item.payload;
        n_job.home    = home_slot(i_item.key);
        n_job.bad     = (i_item.key == '0);
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

// ----- design/lpht_queue.sv -----
// two-entry job queue between front and back
`default_nettype none
module lpht_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  lpht_pkg::t_job   i_job,
    output logic             o_valid,
    input  wire              i_stall,
    output lpht_pkg::t_job   o_job
);
    import lpht_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_stall = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ----- design/lpht_back.sv -----
// back end: probe sequencer over the slot stores, plus the result register
`default_nettype none
module lpht_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  lpht_pkg::t_job   i_job,
    output logic             o_valid,
    input  wire              i_stall,
    output lpht_pkg::t_out   o_res
);
    import lpht_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    t_job              r_job;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    t_out              r_res, n_res;
    logic [SLOTS-1:0]  r_used;
    logic [KEY_W-1:0]  r_rd_key;
    logic [PAY_W-1:0]  r_rd_pay;
    logic              r_out_valid;
    t_out              r_out;

    logic [KEY_W-1:0]  r_key_mem [SLOTS];
    logic [PAY_W-1:0]  r_pay_mem [SLOTS];

    logic take;
    logic wr_en;
    logic out_load;
    logic empty;
    logic last;

    assign o_stall  = (r_state != S_IDLE);
    assign take     = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign empty    = !r_used[r_pos];
    assign last     = (r_cnt == SLOT_W'(SLOTS - 1));
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // probe sequencer
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_res   = r_res;
        wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pos = i_job.home;
                    n_cnt = '0;
                    if (i_job.bad) begin
                        n_res   = '{status: ST_BAD_KEY, slot: '0, found_payload: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_job.kind == KIND_INSERT && empty) begin
                    wr_en   = 1'b1;
                    n_res   = '{status: ST_INSERTED, slot: r_pos, found_payload: '0};
                    n_state = S_DONE;
                end else if (r_job.kind == KIND_LOOKUP && empty) begin
                    n_res   = '{status: ST_NOT_FOUND, slot: '0, found_payload: '0};
                    n_state = S_DONE;
                end else if (r_job.kind == KIND_LOOKUP && r_rd_key == r_job.key) begin
                    n_res   = '{status: ST_FOUND, slot: r_pos, found_payload: r_rd_pay};
                    n_state = S_DONE;
                end else if (last) begin
                    n_res.status        = (r_job.kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_res.slot          = '0;
                    n_res.found_payload = '0;
                    n_state             = S_DONE;
                end else begin
                    n_pos   = (r_pos == SLOT_W'(SLOTS - 1)) ? '0 : r_pos + SLOT_W'(1);
                    n_cnt   = r_cnt + SLOT_W'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_used[r_pos] <= 1'b1;
            end
        end
    end

    // job and probe datapath registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        r_pos <= n_pos;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    // slot stores with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[r_pos] <= r_job.key;
            r_pay_mem[r_pos] <= r_job.payload;
        end
        r_rd_key <= r_key_mem[r_pos];
        r_rd_pay <= r_pay_mem[r_pos];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire

// ----- design/linear_probe_hash_table_top.sv -----
// top level of the linear probe hash table
`default_nettype none
`include "linear_probe_hash_table_top_defines.svh"
// Open-addressed hash table of 31 slots with linear probing. Each item is an
// insert or a lookup; each gives exactly one result. A front stage registers
// the item, rejects key zero and folds the key into its home slot (key mod 31);
// a two-entry queue feeds the probe engine, so new items are taken while the
// engine works. The engine handles one item at a time: it picks up a job, then
// for each probe does a registered read of the key store and then a compare,
// and then hands the result to the output register; an invalid key skips the
// probes, and a full table is probed in every slot. Slot occupancy is held in
// flip-flops cleared by reset, so the table is usable directly after reset
// with no clearing pass.
module linear_probe_hash_table_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  lpht_pkg::t_in    i_item,
    output logic             o_valid,
    input  wire              i_stall,
    output lpht_pkg::t_out   o_res
);
    import lpht_pkg::*;

    logic f_valid;
    logic f_stall;
    t_job f_job;
    logic q_valid;
    logic q_stall;
    t_job q_job;
    logic is_found;
    logic pay_zero;
    logic slotless;

    // classify
    lpht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_job   (f_job)
    );

    // decouple
    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_job   (q_job)
    );

    // probe and respond
    lpht_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_stall (q_stall),
        .i_job   (q_job),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // result classes seen by the checks below
    assign is_found = (o_res.status == ST_FOUND);
    assign pay_zero = (o_res.found_payload == '0);
    assign slotless = (o_res.status == ST_NOT_FOUND) || (o_res.status == ST_FULL) ||
                      (o_res.status == ST_BAD_KEY);

    // payload only comes back with a found lookup
    `LPHT_ASSERT_IMPLY(a_pay_zero, i_clk, i_rst_n, o_valid && !is_found, pay_zero)
    // no slot reported when nothing was written or matched
    `LPHT_ASSERT_IMPLY(a_slot_zero, i_clk, i_rst_n, o_valid && slotless, o_res.slot == '0)
    // a job blocked by a full queue is not dropped
    `LPHT_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, f_valid && f_stall, f_valid)

endmodule
`default_nettype wire
